[src/url_percent_codec_assert.svh]
// Assertion macros for the codec modules.
`ifndef URL_PERCENT_CODEC_ASSERT_SVH
`define URL_PERCENT_CODEC_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define URL_PCT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("url_percent_codec: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define URL_PCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("url_percent_codec: next-cycle check failed");

`endif

[src/url_pct_pkg.sv]
package url_pct_pkg;

   // Default number of words held between the front and the back.
   localparam int DEFAULT_QUEUE_DEPTH = 4;

   localparam logic [7:0] PERCENT_CHAR = 8'h25;
   localparam logic [7:0] NUL_CHAR     = 8'h00;

   // One bit per byte value: set for letters, digits, '-', '.', '_' and '~'.
   localparam logic [7:0] UNRESERVED_MAP [32] = '{
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h60, 8'hff, 8'h03,
      8'hfe, 8'hff, 8'hff, 8'h87, 8'hfe, 8'hff, 8'hff, 8'h47,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   // Decoder phase: pass-through, first hex digit, second hex digit, drop.
   typedef enum logic [1:0] {
      PHASE_PASS = 2'd0,
      PHASE_HIGH = 2'd1,
      PHASE_LOW  = 2'd2,
      PHASE_DROP = 2'd3
   } phase_type;

   // Output beat of an escape sequence in encode mode.
   typedef enum logic [1:0] {
      BEAT_PERCENT = 2'd0,
      BEAT_HIGH    = 2'd1,
      BEAT_LOW     = 2'd2
   } beat_type;

   // Command word from the front to the back. An escape word expands into
   // three results, any other word is one result as it stands.
   typedef struct packed {
      logic       escape;
      logic [7:0] data;
      logic       has_byte;
      logic       end_of_message;
      logic       error;
   } cmd_type;

   function automatic logic is_unreserved(input logic [7:0] b);
      logic [7:0] row;
      row = UNRESERVED_MAP[b[7:3]];
      return row[b[2:0]];
   endfunction

   // Uppercase ASCII hex digit of a nibble.
   function automatic logic [7:0] hex_upper(input logic [3:0] nib);
      if (nib < 4'd10) begin
         return 8'h30 + {4'h0, nib};
      end
      return 8'h37 + {4'h0, nib};
   endfunction

   // Digit value in the low four bits; bit 4 set means not a hex digit.
   function automatic logic [4:0] hex_value(input logic [7:0] b);
      logic [7:0] d;
      d = 8'h00;
      if (b >= 8'h30 && b <= 8'h39) begin
         d = b - 8'h30;
      end else if (b >= 8'h61 && b <= 8'h66) begin
         d = b - 8'h57;
      end else if (b >= 8'h41 && b <= 8'h46) begin
         d = b - 8'h37;
      end else begin
         return 5'h10;
      end
      return {1'b0, d[3:0]};
   endfunction

endpackage

[src/url_pct_req_if.sv]
interface url_pct_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       last_byte;

   modport source (output valid, output in_byte, output last_byte, input ready);
   modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

[src/url_pct_rsp_if.sv]
interface url_pct_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       has_byte;
   logic       end_of_message;
   logic       error;

   modport source (output valid, output out_byte, output has_byte,
                   output end_of_message, output error, input ready);
   modport sink   (input valid, input out_byte, input has_byte,
                   input end_of_message, input error, output ready);
endinterface

[src/url_pct_front.sv]
module url_pct_front (
   input  logic                clock,
   input  logic                reset,
   url_pct_req_if.sink         req_ch,
   input  logic                csr_write_en,
   input  logic                csr_write_data,
   input  logic                queue_full,
   output logic                push,
   output url_pct_pkg::cmd_type push_word
);
   import url_pct_pkg::*;

   logic       decode_mode_ff, decode_mode_in;
   phase_type  phase_ff, phase_in;
   logic [3:0] high_nibble_ff, high_nibble_in;

   logic       accept;
   logic [7:0] b;
   logic       last;
   logic [4:0] hv;
   logic       bad_hex;
   logic       emit;

   assign req_ch.ready = !queue_full;
   assign accept  = req_ch.valid && req_ch.ready;
   assign b       = req_ch.in_byte;
   assign last    = req_ch.last_byte;
   assign hv      = hex_value(b);
   assign bad_hex = hv[4];

   // Next mode, phase and held nibble for a mode write or an accepted word.
   always_comb begin
      decode_mode_in = decode_mode_ff;
      phase_in       = phase_ff;
      high_nibble_in = high_nibble_ff;
      if (csr_write_en) begin
         decode_mode_in = csr_write_data;
         phase_in       = PHASE_PASS;
         high_nibble_in = 4'h0;
      end else if (accept) begin
         unique case (phase_ff)
            PHASE_PASS: begin
               if (b == NUL_CHAR) begin
                  phase_in = PHASE_DROP;
               end else if (decode_mode_ff && b == PERCENT_CHAR) begin
                  phase_in = PHASE_HIGH;
               end
            end
            PHASE_HIGH: begin
               if (bad_hex) begin
                  phase_in = PHASE_DROP;
               end else begin
                  high_nibble_in = hv[3:0];
                  phase_in       = PHASE_LOW;
               end
            end
            PHASE_LOW: begin
               phase_in = bad_hex ? PHASE_DROP : PHASE_PASS;
            end
            PHASE_DROP: begin
               phase_in = PHASE_DROP;
            end
            default: begin
               phase_in = PHASE_PASS;
            end
         endcase
         // A message always closes in pass-through.
         if (last) begin
            phase_in = PHASE_PASS;
         end
      end
   end

   // Command word that an accepted word produces, if any.
   always_comb begin
      emit = 1'b0;
      push_word = '{escape: 1'b0, data: 8'h00, has_byte: 1'b0,
                    end_of_message: last, error: 1'b0};
      unique case (phase_ff)
         PHASE_PASS: begin
            if (b == NUL_CHAR) begin
               emit = last;
            end else if (!decode_mode_ff) begin
               emit = 1'b1;
               push_word.data = b;
               if (is_unreserved(b)) begin
                  push_word.has_byte = 1'b1;
               end else begin
                  push_word.escape = 1'b1;
               end
            end else if (b == PERCENT_CHAR) begin
               // An escape cut off by the end of the message.
               emit = last;
               push_word.error = 1'b1;
            end else begin
               emit = 1'b1;
               push_word.data     = b;
               push_word.has_byte = 1'b1;
            end
         end
         PHASE_HIGH: begin
            if (bad_hex || last) begin
               emit = 1'b1;
               push_word.error = 1'b1;
            end
         end
         PHASE_LOW: begin
            emit = 1'b1;
            if (bad_hex) begin
               push_word.error = 1'b1;
            end else begin
               push_word.data     = {high_nibble_ff, hv[3:0]};
               push_word.has_byte = 1'b1;
            end
         end
         PHASE_DROP: begin
            emit = last;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   assign push = accept && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         decode_mode_ff <= 1'b0;
         phase_ff       <= PHASE_PASS;
         high_nibble_ff <= 4'h0;
      end else begin
         decode_mode_ff <= decode_mode_in;
         phase_ff       <= phase_in;
         high_nibble_ff <= high_nibble_in;
      end
   end

endmodule

[src/url_pct_fifo.sv]
module url_pct_fifo #(
   parameter int DEPTH = url_pct_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  url_pct_pkg::cmd_type push_word,
   input  logic                 pop,
   output url_pct_pkg::cmd_type head_word,
   output logic                 not_empty,
   output logic                 full
);
   import url_pct_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   cmd_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == FULL_CNT);
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head_word = mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage for queued words.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

[src/url_pct_back.sv]
module url_pct_back (
   input  logic                 clock,
   input  logic                 reset,
   input  url_pct_pkg::cmd_type head_word,
   input  logic                 head_valid,
   output logic                 pop,
   url_pct_rsp_if.source        rsp_ch
);
   import url_pct_pkg::*;

   beat_type   beat_ff, beat_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_has_ff, out_has_in;
   logic       out_eom_ff, out_eom_in;
   logic       out_err_ff, out_err_in;

   logic       load;
   logic       last_beat;

   assign load      = head_valid && (!out_valid_ff || rsp_ch.ready);
   assign last_beat = !head_word.escape || (beat_ff == BEAT_LOW);
   assign pop       = load && last_beat;

   // Next beat within the word at the queue head.
   always_comb begin
      beat_in = beat_ff;
      if (load) begin
         if (last_beat) begin
            beat_in = BEAT_PERCENT;
         end else begin
            unique case (beat_ff)
               BEAT_PERCENT: beat_in = BEAT_HIGH;
               BEAT_HIGH:    beat_in = BEAT_LOW;
               default:      beat_in = BEAT_PERCENT;
            endcase
         end
      end
   end

   // Result for the current beat.
   always_comb begin
      out_byte_in = head_word.data;
      out_has_in  = head_word.has_byte;
      out_eom_in  = head_word.end_of_message;
      out_err_in  = head_word.error;
      if (head_word.escape) begin
         out_has_in = 1'b1;
         out_err_in = 1'b0;
         unique case (beat_ff)
            BEAT_PERCENT: begin
               out_byte_in = PERCENT_CHAR;
               out_eom_in  = 1'b0;
            end
            BEAT_HIGH: begin
               out_byte_in = hex_upper(head_word.data[7:4]);
               out_eom_in  = 1'b0;
            end
            BEAT_LOW: begin
               out_byte_in = hex_upper(head_word.data[3:0]);
            end
            default: begin
               out_byte_in = PERCENT_CHAR;
               out_eom_in  = 1'b0;
            end
         endcase
      end
   end

   // The output register drains as the sink takes it.
   always_comb begin
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff      <= BEAT_PERCENT;
         out_valid_ff <= 1'b0;
      end else begin
         beat_ff      <= beat_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_byte_ff <= out_byte_in;
         out_has_ff  <= out_has_in;
         out_eom_ff  <= out_eom_in;
         out_err_ff  <= out_err_in;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.out_byte       = out_byte_ff;
   assign rsp_ch.has_byte       = out_has_ff;
   assign rsp_ch.end_of_message = out_eom_ff;
   assign rsp_ch.error          = out_err_ff;

`include "url_percent_codec_assert.svh"

   // Only an escape word is ever part way through its beats.
   `URL_PCT_ASSERT_IMP(a_beat_escape, clock, reset, beat_ff != BEAT_PERCENT, head_valid && head_word.escape)
   // The head word leaves the queue only when its final result is loaded.
   `URL_PCT_ASSERT_IMP(a_pop_on_load, clock, reset, pop, load && last_beat)
   // The first beat of an escape shows a percent sign that does not close the message.
   `URL_PCT_ASSERT_NEXT(a_escape_percent, clock, reset, load && head_word.escape && beat_ff == BEAT_PERCENT, out_byte_ff == PERCENT_CHAR && !out_eom_ff && out_has_ff)

endmodule

[src/url_percent_codec.sv]
// Percent-encoding codec for byte strings.
// The req_ch channel takes one source byte a word, with a flag on the last
// byte of a message; rsp_ch gives result words: a byte with has_byte set,
// or a status word, with end_of_message on the final result of a message
// and error on a decoding failure. csr_write_en and csr_write_data select
// encode (0) or decode (1) and clear any escape or drop in progress.
// A taken byte is written into the queue, and its first result is then
// loaded into the output register. Throughput is one byte per cycle while
// each byte gives one result or none and the receiver takes every result;
// an escaped byte in encode mode holds the output register for three
// results, and the queue of QUEUE_DEPTH words between the classifier and
// the output stage absorbs that until it fills and req_ch.ready drops.
// Reset returns the block to encode mode in pass-through with the queue
// and output register empty. When the receiver stalls, the output word
// holds, the queue fills, and the source is then held off.
module url_percent_codec #(
   parameter int QUEUE_DEPTH = url_pct_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   url_pct_req_if.sink   req_ch,
   url_pct_rsp_if.source rsp_ch,
   input  logic          csr_write_en,
   input  logic          csr_write_data
);
   import url_pct_pkg::*;

   logic    push, pop, queue_full, head_valid;
   cmd_type push_word, head_word;

   url_pct_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .queue_full     (queue_full),
      .push           (push),
      .push_word      (push_word)
   );

   url_pct_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop       (pop),
      .head_word (head_word),
      .not_empty (head_valid),
      .full      (queue_full)
   );

   url_pct_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_word  (head_word),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
   import url_pct_pkg::*;

   localparam bit MODE_ENCODE = 1'b0;
   localparam bit MODE_DECODE = 1'b1;
   // Mode of each random phase, bit p for phase p.
   localparam bit [6:0] PHASE_MODE = 7'b1011001;
   localparam int NUM_PHASES = 7;
   localparam int PHASE_ITEMS = 30;
   localparam int IDLE_PERCENT = 12;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int HOLD_PHASE = 2;
   localparam int QUIET_PHASE = 4;
   localparam int TIMEOUT_NS = 400_000;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       end_of_message;
      logic       error;
   } codec_word_type;

   // Tracks the codec state and holds the result words still owed by the block.
   class codec_checker;
      bit             decode_mode;
      phase_type      phase;
      logic [3:0]     high_nibble;
      codec_word_type pending_words[$];
      int             mismatches;
      int             words_checked;

      function new();
         clear(MODE_ENCODE);
         mismatches = 0;
         words_checked = 0;
      endfunction

      // A mode write also abandons any escape or drop in progress.
      function void clear(bit mode);
         decode_mode = mode;
         phase = PHASE_PASS;
         high_nibble = 4'h0;
      endfunction

      function bit is_unreserved(logic [7:0] b);
         return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") ||
                (b >= "0" && b <= "9") || b == "-" || b == "." || b == "_" || b == "~";
      endfunction

      // Bit 4 set means the byte is not a hex digit.
      function logic [4:0] digit_value(logic [7:0] b);
         logic [7:0] v;
         if (b >= "0" && b <= "9") begin
            v = b - 8'h30;
         end else if (b >= "a" && b <= "f") begin
            v = b - 8'h61 + 8'd10;
         end else if (b >= "A" && b <= "F") begin
            v = b - 8'h41 + 8'd10;
         end else begin
            return 5'h10;
         end
         return {1'b0, v[3:0]};
      endfunction

      function logic [7:0] upper_hex(logic [3:0] n);
         return (n < 4'd10) ? (8'h30 + 8'(n)) : (8'h41 + 8'(n) - 8'd10);
      endfunction

      function void push(logic [7:0] b, logic has, logic eom, logic err);
         codec_word_type w;
         w.out_byte = b;
         w.has_byte = has;
         w.end_of_message = eom;
         w.error = err;
         pending_words.push_back(w);
      endfunction

      // Works out the result words caused by one accepted source byte.
      function void take_byte(logic [7:0] b, logic last);
         logic [4:0] dv;
         case (phase)
            PHASE_DROP: begin
               if (last) push(8'h00, 1'b0, 1'b1, 1'b0);
            end
            PHASE_PASS: begin
               if (b == NUL_CHAR) begin
                  if (last) push(8'h00, 1'b0, 1'b1, 1'b0);
                  else phase = PHASE_DROP;
               end else if (decode_mode == MODE_ENCODE) begin
                  if (is_unreserved(b)) begin
                     push(b, 1'b1, last, 1'b0);
                  end else begin
                     push(PERCENT_CHAR, 1'b1, 1'b0, 1'b0);
                     push(upper_hex(b[7:4]), 1'b1, 1'b0, 1'b0);
                     push(upper_hex(b[3:0]), 1'b1, last, 1'b0);
                  end
               end else if (b == PERCENT_CHAR) begin
                  if (last) push(8'h00, 1'b0, 1'b1, 1'b1);
                  else phase = PHASE_HIGH;
               end else begin
                  push(b, 1'b1, last, 1'b0);
               end
            end
            default: begin
               dv = digit_value(b);
               if (dv[4]) begin
                  push(8'h00, 1'b0, last, 1'b1);
                  phase = PHASE_DROP;
               end else if (phase == PHASE_HIGH) begin
                  high_nibble = dv[3:0];
                  if (last) push(8'h00, 1'b0, 1'b1, 1'b1);
                  else phase = PHASE_LOW;
               end else begin
                  push({high_nibble, dv[3:0]}, 1'b1, last, 1'b0);
                  phase = PHASE_PASS;
               end
            end
         endcase
         if (last) phase = PHASE_PASS;
      endfunction

      // Compares one accepted result word with the oldest one owed.
      function void match_word(codec_word_type got);
         codec_word_type want;
         words_checked++;
         if (pending_words.size() == 0) begin
            $error("unexpected result word: out_byte %h has_byte %b eom %b error %b",
                   got.out_byte, got.has_byte, got.end_of_message, got.error);
            mismatches++;
            return;
         end
         want = pending_words.pop_front();
         if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
            mismatches++;
         end
         if (got.has_byte !== want.has_byte) begin
            $error("has_byte: expected %b, got %b", want.has_byte, got.has_byte);
            mismatches++;
         end
         if (got.end_of_message !== want.end_of_message) begin
            $error("end_of_message: expected %b, got %b",
                   want.end_of_message, got.end_of_message);
            mismatches++;
         end
         if (got.error !== want.error) begin
            $error("error: expected %b, got %b", want.error, got.error);
            mismatches++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_en;
   logic csr_write_data;

   url_pct_req_if req_ch();
   url_pct_rsp_if rsp_ch();

   codec_checker checker_h;
   logic [7:0]   source_bytes[$];
   string        plain_chars =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-._~";
   bit           no_idle = 1'b0;
   bit           hold_request = 1'b0;
   int           bytes_sent = 0;
   int           live_bytes = 0;
   int           mode_writes = 0;

   url_percent_codec dut (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   // Free-running clock.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Offers one source byte, with random idle cycles ahead of it.
   task automatic send_byte(input logic [7:0] b, input logic last);
      while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.in_byte <= b;
      req_ch.last_byte <= last;
      do @(posedge clock); while (!req_ch.ready);
      if (checker_h.phase != PHASE_DROP) live_bytes++;
      checker_h.take_byte(b, last);
      bytes_sent++;
   endtask

   // Sends the queued bytes as one message, last flag on the final byte.
   task automatic send_message();
      for (int i = 0; i < source_bytes.size(); i++) begin
         send_byte(source_bytes[i], i == source_bytes.size() - 1);
      end
   endtask

   // Writes the mode once the block has gone quiet.
   task automatic set_mode(input bit mode);
      req_ch.valid <= 1'b0;
      while (checker_h.pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= mode;
      @(posedge clock);
      csr_write_en <= 1'b0;
      checker_h.clear(mode);
      mode_writes++;
   endtask

   function automatic logic [7:0] random_hex_digit();
      logic [3:0] n;
      n = 4'($urandom_range(15));
      if (n < 4'd10) return 8'h30 + 8'(n);
      return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
   endfunction

   // Builds a random message: mostly well formed, with some noise mixed in.
   task automatic build_message(input bit mode);
      int         count;
      int         kind;
      logic [7:0] b;
      source_bytes.delete();
      if (mode == MODE_ENCODE) begin
         count = $urandom_range(1, 8);
         repeat (count) begin
            kind = $urandom_range(99);
            if (kind < 50) b = plain_chars[$urandom_range(plain_chars.len() - 1)];
            else if (kind < 96) b = 8'($urandom_range(1, 255));
            else b = NUL_CHAR;
            source_bytes.push_back(b);
         end
      end else begin
         count = $urandom_range(1, 5);
         repeat (count) begin
            kind = $urandom_range(99);
            if (kind < 45) begin
               source_bytes.push_back(PERCENT_CHAR);
               source_bytes.push_back(random_hex_digit());
               source_bytes.push_back(random_hex_digit());
            end else if (kind < 85) begin
               do b = 8'($urandom_range(1, 255)); while (b == PERCENT_CHAR);
               source_bytes.push_back(b);
            end else if (kind < 92) begin
               // Escape whose digit is usually not hex.
               source_bytes.push_back(PERCENT_CHAR);
               source_bytes.push_back(8'($urandom_range(255)));
            end else if (kind < 96) begin
               source_bytes.push_back(NUL_CHAR);
            end else begin
               // A lone escape start; truncated when it ends the message.
               source_bytes.push_back(PERCENT_CHAR);
            end
         end
      end
   endtask

   // Result side: checks each accepted word and drives ready, with one long hold-off.
   initial begin : result_sink
      int             hold_left;
      codec_word_type got;
      hold_left = 0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.out_byte = rsp_ch.out_byte;
            got.has_byte = rsp_ch.has_byte;
            got.end_of_message = rsp_ch.end_of_message;
            got.error = rsp_ch.error;
            checker_h.match_word(got);
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // Stimulus: directed messages, then random phases in both modes.
   initial begin : stimulus
      int phase_start;
      checker_h = new();
      req_ch.valid = 1'b0;
      req_ch.in_byte = 8'h00;
      req_ch.last_byte = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_write_en = 1'b0;
      csr_write_data = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Encode after reset: pass-through, escapes of the top byte and of '%'.
      source_bytes = '{"z", 8'hff, PERCENT_CHAR};
      send_message();
      // A zero byte ends the string; the rest is dropped up to the last flag.
      source_bytes = '{"A", NUL_CHAR, "B", 8'h01};
      send_message();
      source_bytes = '{NUL_CHAR};
      send_message();

      // Decode: plain escapes, a decoded zero, mixed-case hex, a bad digit.
      set_mode(MODE_DECODE);
      source_bytes = '{PERCENT_CHAR, "4", "1", PERCENT_CHAR, "0", "0"};
      send_message();
      source_bytes = '{PERCENT_CHAR, "a", "F", PERCENT_CHAR, "g", "x"};
      send_message();
      // Escapes cut off by the end of the message.
      source_bytes = '{PERCENT_CHAR};
      send_message();
      source_bytes = '{PERCENT_CHAR, "7"};
      send_message();
      // A zero byte inside an escape counts as a bad digit.
      source_bytes = '{PERCENT_CHAR, "3", NUL_CHAR};
      send_message();
      // A mode write abandons a partial escape.
      send_byte(PERCENT_CHAR, 1'b0);
      send_byte("4", 1'b0);
      set_mode(MODE_DECODE);
      source_bytes = '{"4", "1"};
      send_message();

      // Random phases.
      for (int p = 0; p < NUM_PHASES; p++) begin
         set_mode(PHASE_MODE[p]);
         no_idle = (p == QUIET_PHASE);
         if (p == HOLD_PHASE) hold_request = 1'b1;
         phase_start = live_bytes;
         while (live_bytes - phase_start < PHASE_ITEMS) begin
            build_message(PHASE_MODE[p]);
            send_message();
         end
      end
      no_idle = 1'b0;

      // Let the block drain, then report.
      req_ch.valid <= 1'b0;
      while (checker_h.pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("summary: %0d source bytes (%0d outside drops), %0d result words, %0d mode writes",
               bytes_sent, live_bytes, checker_h.words_checked, mode_writes);
      $display("summary: encode and decode, truncated and bad escapes, zero bytes, long stall");
      if (checker_h.mismatches == 0 && checker_h.pending_words.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog.
   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("tb: failure");
      $finish;
   end

endmodule

[sim.f]
+incdir+src
src/url_pct_pkg.sv
src/url_pct_req_if.sv
src/url_pct_rsp_if.sv
src/url_pct_front.sv
src/url_pct_fifo.sv
src/url_pct_back.sv
src/url_percent_codec.sv
tb/testbench.sv
